/* rtl/state_feedback_gain_controller_unit_assert.svh */
// Assertion macros for the state feedback gain controller RTL.
// Included by the top-level module, which carries concurrent checks; no other dependencies.
`ifndef STATE_FEEDBACK_GAIN_CONTROLLER_UNIT_ASSERT_SVH
`define STATE_FEEDBACK_GAIN_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFGC_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFGC_ASSERT_NXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/sfg_pkg.sv */
// Shared types, widths and the gain ROM of the state feedback gain controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfg_pkg;

    // Vector layout
    localparam int NUM_PAIRED_SENSORS  = 10;
    localparam int NUM_INTEGRAL_STATES = 5;
    localparam int NUM_OUTPUTS         = 5;
    localparam int VEC_LEN             = NUM_PAIRED_SENSORS + NUM_INTEGRAL_STATES;

    // Datapath widths
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = GAIN_W + SAMPLE_W;
    localparam int ACC_W       = 58;
    localparam int NEG_W       = ACC_W + 1;
    localparam int FRAC_SHIFT  = 30;
    localparam int Q_W         = NEG_W - FRAC_SHIFT;
    localparam int CMD_W       = 16;
    localparam int IDX_W       = 3;
    localparam int POS_W       = $clog2(VEC_LEN);
    localparam int TDATA_W     = ((CMD_W + IDX_W + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - CMD_W - IDX_W;

    // Alignment of products to the 2^-39 accumulator LSB
    localparam int SHIFT_HEIGHT   = 3;
    localparam int SHIFT_INTEGRAL = 10;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(VEC_LEN - 1);
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(NUM_OUTPUTS - 1);

    localparam logic [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
    localparam logic [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        KIND_HEIGHT,
        KIND_FLOW,
        KIND_INTEGRAL
    } pos_kind_t;

    // Sample travelling from cell to cell
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        pos_t                       pos;
    } sfg_link_t;

    // Accumulator leaving the chain toward the output stage
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
        logic [IDX_W-1:0]        row;
        logic                    last;
    } sfg_drain_t;

    // Gains in signed Q11.20, one row per actuator
    localparam logic signed [GAIN_W-1:0] GAIN_ROM [NUM_OUTPUTS][VEC_LEN] = '{
        '{ 32'sd126803867, 32'sd62338590, 32'sd39387523, 32'sd19569477, 32'sd86293579,
           32'sd42694250, 32'sd77987785, 32'sd38615628, 32'sd106077153, 32'sd52304928,
           32'sd1064767, 32'sd249568, 32'sd453074, 32'sd378784, 32'sd489099 },
        '{ -32'sd27482442, -32'sd13099787, 32'sd69372133, 32'sd34244631, 32'sd102995788,
           32'sd50788794, 32'sd87496508, 32'sd43241783, 32'sd116678107, 32'sd57411488,
           -32'sd451934, 32'sd888562, 32'sd710548, 32'sd507669, 32'sd618377 },
        '{ -32'sd13783732, -32'sd6706086, -32'sd36294632, -32'sd17533330, 32'sd121173497,
           32'sd59436440, 32'sd90799877, 32'sd44809961, 32'sd118265221, 32'sd58124080,
           -32'sd181695, -32'sd716215, 32'sd1153679, 32'sd591885, 32'sd672354 },
        '{ -32'sd4549968, -32'sd2220811, -32'sd6441683, -32'sd3173829, -32'sd46775313,
           -32'sd22166427, 32'sd151515085, 32'sd73985980, 32'sd155381319, 32'sd75918334,
           -32'sd53497, -32'sd91942, -32'sd818180, 32'sd1784027, 32'sd1181550 },
        '{ -32'sd2047857, -32'sd1000396, -32'sd2578056, -32'sd1271830, -32'sd13922951,
           -32'sd6760409, -32'sd63228161, -32'sd29503344, 32'sd212957058, 32'sd102873343,
           -32'sd23274, -32'sd33845, -32'sd195528, -32'sd1250310, 32'sd2403458 }
    };

    // Kind of state element at a vector position
    function automatic pos_kind_t pos_kind(input pos_t pos);
        pos_kind_t kind;
        if (pos < POS_W'(NUM_PAIRED_SENSORS)) begin
            kind = pos[0] ? KIND_FLOW : KIND_HEIGHT;
        end else begin
            kind = KIND_INTEGRAL;
        end
        return kind;
    endfunction

endpackage

/* rtl/sfg_cell.sv */
// One multiply-accumulate cell of the gain chain, owning one actuator row.
// Depends on sfg_pkg for the link type, widths and the gain ROM.
`timescale 1ns / 1ps

module sfg_cell
    import sfg_pkg::*;
#(
    parameter int ROW = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sfg_link_t               link_i,
    output sfg_link_t               link_o,
    input  logic                    shift_i,
    input  logic signed [ACC_W-1:0] acc_i,
    output logic signed [ACC_W-1:0] acc_o,
    output logic                    busy_o
);

    sfg_link_t               link_reg;
    logic                    prod_valid_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [GAIN_W-1:0] gain;
    logic signed [PROD_W-1:0] mul;
    logic signed [ACC_W-1:0]  wide;
    logic signed [ACC_W-1:0]  aligned;

    // Gain lookup and product, aligned to the accumulator LSB
    assign gain = GAIN_ROM[ROW][link_reg.pos];
    assign mul  = PROD_W'(gain) * PROD_W'(link_reg.sample);
    assign wide = ACC_W'(mul);

    always_comb begin
        unique case (pos_kind(link_reg.pos))
            KIND_FLOW:     aligned = wide;
            KIND_HEIGHT:   aligned = wide <<< SHIFT_HEIGHT;
            KIND_INTEGRAL: aligned = wide <<< SHIFT_INTEGRAL;
            default:       aligned = wide;
        endcase
    end

    // Sample hop, product register and accumulator / drain shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg       <= '0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else begin
            link_reg       <= link_i;
            prod_valid_reg <= link_reg.valid;
            if (shift_i) begin
                acc_reg <= acc_i;
            end else if (prod_valid_reg) begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (link_reg.valid) begin
            prod_reg <= aligned;
        end
    end

    assign link_o = link_reg;
    assign acc_o  = acc_reg;
    assign busy_o = link_reg.valid | prod_valid_reg;

endmodule

/* rtl/sfg_out.sv */
// Output stage: negate, scale by 2^-30 toward zero, saturate, register.
// Depends on sfg_pkg for the drain type and widths.
`timescale 1ns / 1ps

module sfg_out
    import sfg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  sfg_drain_t         drain_i,
    output logic               ready_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // command[15:0], actuator_index[18:16], zero pad
    output logic               m_tlast,
    output logic               m_tuser    // saturated
);

    logic                    a_valid_reg;
    logic signed [NEG_W-1:0] a_neg_reg;
    logic [IDX_W-1:0]        a_row_reg;
    logic                    a_last_reg;

    logic                    m_valid_reg;
    logic [CMD_W-1:0]        m_cmd_reg;
    logic [IDX_W-1:0]        m_row_reg;
    logic                    m_last_reg;
    logic                    m_sat_reg;

    logic                    b_take;
    logic signed [NEG_W-1:0] bias;
    logic signed [NEG_W-1:0] biased;
    logic [Q_W-1:0]          q;
    logic [Q_W-CMD_W:0]      upper;
    logic                    in_range;
    logic [CMD_W-1:0]        cmd;

    assign b_take  = !m_valid_reg || m_tready;
    assign ready_o = !a_valid_reg || b_take;

    // Truncate toward zero: bias negative values before the arithmetic shift
    assign bias     = a_neg_reg[NEG_W-1] ? {{(NEG_W-FRAC_SHIFT){1'b0}}, {FRAC_SHIFT{1'b1}}}
                                         : '0;
    assign biased   = a_neg_reg + bias;
    assign q        = biased[NEG_W-1:FRAC_SHIFT];
    assign upper    = q[Q_W-1:CMD_W-1];
    assign in_range = (&upper) | ~(|upper);
    assign cmd      = in_range ? q[CMD_W-1:0] : (q[Q_W-1] ? CMD_MIN : CMD_MAX);

    // Valid flags of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ready_o) begin
                a_valid_reg <= drain_i.valid;
            end
            if (b_take) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ready_o && drain_i.valid) begin
            a_neg_reg  <= -NEG_W'(drain_i.acc);
            a_row_reg  <= drain_i.row;
            a_last_reg <= drain_i.last;
        end
        if (b_take && a_valid_reg) begin
            m_cmd_reg  <= cmd;
            m_row_reg  <= a_row_reg;
            m_last_reg <= a_last_reg;
            m_sat_reg  <= !in_range;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_row_reg, m_cmd_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_sat_reg;

endmodule

/* rtl/state_feedback_gain_controller_unit.sv */
// Usage:
//   Slave channel (s_*): one signed 16-bit state sample per transaction, in
//   vector order: five height/flow pairs, then five integral heights.
//   Master channel (m_*): after every fifteenth sample, five transactions carry
//   u = -K x for actuator rows 0..4; tuser flags a clipped command and tlast
//   marks row 4.
//   Within a run a sample is taken every cycle; each sample walks a chain of
//   five cells (one per actuator row), one cell per cycle, each doing one
//   multiply-accumulate with its gain column entry.
//   After the fifteenth sample s_tready stays low while the chain empties,
//   then while the five accumulators shift out through the output stage,
//   one per cycle while the output stage can take a row. Each command then
//   passes the conversion register and the output register. The spacing of
//   runs without stalls is set by the chain depth and the drain of five rows.
//   If the receiver stalls, the drain waits; the output register and one
//   conversion stage hold results, and the next run starts once all five
//   rows have left the chain.
//   Reset (aresetn low, synchronous) clears the accumulators, the sample
//   position and all valid flags.
// Depends on sfg_pkg, sfg_cell, sfg_out and the assertion macro header.
`timescale 1ns / 1ps

`include "state_feedback_gain_controller_unit_assert.svh"

module state_feedback_gain_controller_unit
    import sfg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,  // sample[15:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // command[15:0], actuator_index[18:16], zero pad
    output logic               m_tlast,
    output logic               m_tuser    // saturated
);

    typedef enum logic [1:0] {
        PH_RUN,
        PH_FLUSH,
        PH_DRAIN
    } phase_t;

    phase_t           phase_reg;
    pos_t             count_reg;
    logic [IDX_W-1:0] row_reg;

    logic                    s_accept;
    logic                    out_ready;
    logic                    drain_shift;
    logic                    chain_busy;
    logic [NUM_OUTPUTS-1:0]  busy;
    sfg_link_t               link [NUM_OUTPUTS+1];
    logic signed [ACC_W-1:0] acc  [NUM_OUTPUTS+1];
    sfg_drain_t              drain;

    assign s_tready    = (phase_reg == PH_RUN);
    assign s_accept    = s_tvalid && s_tready;
    assign drain_shift = (phase_reg == PH_DRAIN) && out_ready;
    assign chain_busy  = |busy;

    // Head of the chain
    assign link[0].valid  = s_accept;
    assign link[0].sample = s_tdata;
    assign link[0].pos    = count_reg;
    assign acc[NUM_OUTPUTS] = '0;

    // Row of cells: samples move toward the tail, accumulators toward the head
    for (genvar r = 0; r < NUM_OUTPUTS; r++) begin : g_cell
        sfg_cell #(
            .ROW (r)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .link_i  (link[r]),
            .link_o  (link[r+1]),
            .shift_i (drain_shift),
            .acc_i   (acc[r+1]),
            .acc_o   (acc[r]),
            .busy_o  (busy[r])
        );
    end

    assign drain.valid = drain_shift;
    assign drain.acc   = acc[0];
    assign drain.row   = row_reg;
    assign drain.last  = (row_reg == ROW_LAST);

    sfg_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .drain_i  (drain),
        .ready_o  (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Run control: collect samples, wait for the chain to empty, drain rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RUN;
            count_reg <= '0;
            row_reg   <= '0;
        end else begin
            unique case (phase_reg)
                PH_RUN: begin
                    if (s_accept) begin
                        if (count_reg == LAST_POS) begin
                            count_reg <= '0;
                            phase_reg <= PH_FLUSH;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                PH_FLUSH: begin
                    if (!chain_busy) begin
                        row_reg   <= '0;
                        phase_reg <= PH_DRAIN;
                    end
                end
                PH_DRAIN: begin
                    if (out_ready) begin
                        if (row_reg == ROW_LAST) begin
                            row_reg   <= '0;
                            phase_reg <= PH_RUN;
                        end else begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    phase_reg <= PH_RUN;
                end
            endcase
        end
    end

    // Checks
    `SFGC_ASSERT_IMP(a_drain_chain_idle, aclk, aresetn, phase_reg == PH_DRAIN, !chain_busy, "accumulators shifted while products still in flight")
    `SFGC_ASSERT_NXT(a_run_closes, aclk, aresetn, s_accept && count_reg == LAST_POS, phase_reg == PH_FLUSH && count_reg == '0, "fifteenth sample did not close the run")
    `SFGC_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg <= LAST_POS, "sample position out of range")
    `SFGC_ASSERT_IMP(a_tail_not_drain, aclk, aresetn, link[NUM_OUTPUTS].valid, phase_reg != PH_DRAIN, "sample still in chain during drain")
    `SFGC_ASSERT_IMP(a_last_row, aclk, aresetn, m_tvalid && m_tlast, m_tdata[CMD_W+IDX_W-1:CMD_W] == ROW_LAST, "tlast on a row other than the final one")

endmodule
